@@ rtl/core/amte_pkg.sv @@
// Shared constants and types of the triangle distortion energy unit.
`timescale 1ns / 1ps

package amte_pkg;

   localparam int COORD_WIDTH_DEF = 32;

   // result format
   localparam int ENERGY_W    = 32;
   localparam int ENERGY_FRAC = 16;
   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
   localparam logic [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

   // sqrt(3) scaled by 2^62
   localparam int SQRT3_SHIFT = 62;
   localparam logic [62:0] SQRT3_Q62 = 63'h6ED9EBA16132A9CE;

   // the sqrt(3) product is built from partial products of 32-bit pieces
   localparam int MUL_W   = 32;
   localparam int SQ_HI_W = 63 - MUL_W;
   localparam logic [MUL_W-1:0]   SQ_LO = SQRT3_Q62[MUL_W-1:0];
   localparam logic [SQ_HI_W-1:0] SQ_HI = SQRT3_Q62[62:MUL_W];

   // rsp_tuser bit positions
   localparam int RSP_USER_W   = 2;
   localparam int USER_DEGEN   = 0;
   localparam int USER_SAT     = 1;

   // divider widths for the default coordinate width
   localparam int DIV_NUM_W_DEF = 2 * COORD_WIDTH_DEF + 85;
   localparam int DIV_DEN_W_DEF = 2 * COORD_WIDTH_DEF + 67;

   typedef struct packed {
      logic neg;
      logic degen;
      logic big;
   } amte_flags_type;

endpackage

@@ rtl/core/amte_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, with overflow check.
`timescale 1ns / 1ps

module amte_divider #(
   parameter int XW  = amte_pkg::DIV_NUM_W_DEF,
   parameter int DDW = amte_pkg::DIV_DEN_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [XW-1:0]                 in_num,
   input  logic [DDW-1:0]                in_den,
   input  amte_pkg::amte_flags_type      in_flags,
   output logic                          out_valid,
   output logic [amte_pkg::ENERGY_W-1:0] out_quo,
   output amte_pkg::amte_flags_type      out_flags
);

   localparam int QB   = amte_pkg::ENERGY_W;
   localparam int HW   = XW - QB;
   localparam int RMW  = DDW + 1;
   localparam int CMPW = (HW > DDW) ? HW : DDW;

   logic                     v_ff     [0:QB];
   logic [RMW-1:0]           rem_ff   [0:QB];
   logic [DDW-1:0]           den_ff   [0:QB];
   logic [QB-1:0]            low_ff   [0:QB];
   logic [QB-1:0]            quo_ff   [0:QB];
   amte_pkg::amte_flags_type flags_ff [0:QB];

   logic [HW-1:0]            num_hi;
   logic                     big;
   logic [RMW-1:0]           rem0_in;
   amte_pkg::amte_flags_type flags0_in;

   // a quotient of 2^QB or more cannot fit: flag it and start from zero
   always_comb begin
      num_hi    = in_num[XW-1:QB];
      big       = CMPW'(num_hi) >= CMPW'(in_den);
      rem0_in   = big ? '0 : RMW'(num_hi);
      flags0_in = in_flags;
      flags0_in.big = big;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]   <= rem0_in;
         den_ff[0]   <= in_den;
         low_ff[0]   <= in_num[QB-1:0];
         quo_ff[0]   <= '0;
         flags_ff[0] <= flags0_in;
      end
   end

   for (genvar g = 0; g < QB; g++) begin : g_step
      logic [RMW-1:0] shifted;
      logic [RMW:0]   diff;
      logic           fits;
      logic [RMW-1:0] rem_in;

      always_comb begin
         shifted = {rem_ff[g][RMW-2:0], low_ff[g][QB-1-g]};
         diff    = {1'b0, shifted} - (RMW+1)'(den_ff[g]);
         fits    = !diff[RMW];
         rem_in  = fits ? diff[RMW-1:0] : shifted;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g+1]   <= rem_in;
            den_ff[g+1]   <= den_ff[g];
            low_ff[g+1]   <= low_ff[g];
            quo_ff[g+1]   <= {quo_ff[g][QB-2:0], fits};
            flags_ff[g+1] <= flags_ff[g];
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign out_quo   = quo_ff[QB];
   assign out_flags = flags_ff[QB];

endmodule

@@ rtl/core/amips_triangle_energy_unit.sv @@
// AMIPS energy of one 2D triangle per cycle when not stalled: edge products, sqrt(3)
// scaling, division. The pipeline has 42 register stages; the 33-stage divider sets
// the depth.
// A one-item skid register keeps req_tready registered and takes an item during a stall.
// Reset (synchronous, active high) clears all valid bits, the skid register's included.
`timescale 1ns / 1ps

module amips_triangle_energy_unit #(
   parameter int COORD_WIDTH = amte_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ax, ay, bx, by, cx, cy from the lowest bit up, zero padded to bytes
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // energy
   output logic [amte_pkg::ENERGY_W-1:0]       rsp_tdata,
   // degenerate, saturated from the lowest bit up
   output logic [amte_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int CW    = COORD_WIDTH;
   localparam int REQW  = ((6*CW+7)/8)*8;
   localparam int DW    = CW + 1;
   localparam int PRW   = 2 * DW;
   localparam int PW    = 2 * CW + 5;
   localparam int QW    = 2 * CW + 4;
   localparam int RW    = 2 * CW + 3;
   localparam int RAW   = RW - 1;
   localparam int MW    = amte_pkg::MUL_W;
   localparam int NCH   = (PW + MW - 1) / MW;
   localparam int SPW   = 2 * CW + 68;
   localparam int NUMW  = SPW + 1;
   localparam int MAGW  = NUMW - 1;
   localparam int XW    = MAGW + amte_pkg::ENERGY_FRAC + 1;
   localparam int DDW   = RAW + 3 + amte_pkg::SQRT3_SHIFT;
   localparam int K     = amte_pkg::SQRT3_SHIFT;
   localparam int EW    = amte_pkg::ENERGY_W;
   localparam int HIW   = MW + amte_pkg::SQ_HI_W;

   // ---------------- skid register and stall control ----------------
   logic            pipe_adv;
   logic            take;
   logic            skid_v_ff;
   logic [REQW-1:0] skid_data_ff;
   logic            rsp_v_ff;
   logic            s0_v;
   logic [REQW-1:0] s0_data;

   assign pipe_adv   = !rsp_v_ff || rsp_tready;
   assign req_tready = !skid_v_ff;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      s0_v    = skid_v_ff || take;
      s0_data = skid_v_ff ? skid_data_ff : req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (pipe_adv) begin
         skid_v_ff <= 1'b0;
      end else if (take) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!pipe_adv && take) begin
         skid_data_ff <= req_tdata;
      end
   end

   // ---------------- stage 1: edge vectors ----------------
   logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
   logic                 s1_v_ff;
   logic signed [DW-1:0] ex_ff, ey_ff, fx_ff, fy_ff;

   always_comb begin
      ax = $signed(s0_data[0*CW +: CW]);
      ay = $signed(s0_data[1*CW +: CW]);
      bx = $signed(s0_data[2*CW +: CW]);
      by = $signed(s0_data[3*CW +: CW]);
      cx = $signed(s0_data[4*CW +: CW]);
      cy = $signed(s0_data[5*CW +: CW]);
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         ex_ff <= DW'(bx) - DW'(ax);
         ey_ff <= DW'(by) - DW'(ay);
         fx_ff <= DW'(cx) - DW'(ax);
         fy_ff <= DW'(cy) - DW'(ay);
      end
   end

   // ---------------- stage 2: eight products ----------------
   logic                  s2_v_ff;
   logic signed [PRW-1:0] m_exex_ff, m_fxfx_ff, m_eyey_ff, m_fyfy_ff;
   logic signed [PRW-1:0] m_exey_ff, m_fxfy_ff, m_exfy_ff, m_eyfx_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         m_exex_ff <= PRW'(ex_ff) * PRW'(ex_ff);
         m_fxfx_ff <= PRW'(fx_ff) * PRW'(fx_ff);
         m_eyey_ff <= PRW'(ey_ff) * PRW'(ey_ff);
         m_fyfy_ff <= PRW'(fy_ff) * PRW'(fy_ff);
         m_exey_ff <= PRW'(ex_ff) * PRW'(ey_ff);
         m_fxfy_ff <= PRW'(fx_ff) * PRW'(fy_ff);
         m_exfy_ff <= PRW'(ex_ff) * PRW'(fy_ff);
         m_eyfx_ff <= PRW'(ey_ff) * PRW'(fx_ff);
      end
   end

   // ---------------- stage 3: P, 2Q and det ----------------
   logic                 s3_v_ff;
   logic [PW-1:0]        sum_x, sum_y, p3_in;
   logic signed [QW-1:0] q_sum, q3_in;
   logic [PW-1:0]        p3_ff;
   logic signed [QW-1:0] q3_ff;
   logic signed [RW-1:0] r3_ff;

   always_comb begin
      sum_x = PW'(m_exex_ff) + PW'(m_fxfx_ff);
      sum_y = PW'(m_eyey_ff) + PW'(m_fyfy_ff);
      p3_in = (sum_x << 1) + sum_x + (sum_y << 2) + sum_y;
      q_sum = QW'(m_exey_ff) + QW'(m_fxfy_ff);
      q3_in = {q_sum[QW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         p3_ff <= p3_in;
         q3_ff <= q3_in;
         r3_ff <= RW'(m_exfy_ff) - RW'(m_eyfx_ff);
      end
   end

   // ---------------- stage 4: sqrt(3) partial products ----------------
   logic                 s4_v_ff;
   logic [NCH*MW-1:0]    p_ext;
   logic [2*MW-1:0]      pplo_in [NCH];
   logic [HIW-1:0]       pphi_in [NCH];
   logic [2*MW-1:0]      pplo_ff [NCH];
   logic [HIW-1:0]       pphi_ff [NCH];
   logic signed [QW-1:0] q4_ff;
   logic signed [RW-1:0] r4_ff;

   always_comb begin
      p_ext = (NCH*MW)'(p3_ff);
      for (int i = 0; i < NCH; i++) begin
         pplo_in[i] = p_ext[i*MW +: MW] * amte_pkg::SQ_LO;
         pphi_in[i] = p_ext[i*MW +: MW] * amte_pkg::SQ_HI;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         pplo_ff <= pplo_in;
         pphi_ff <= pphi_in;
         q4_ff   <= q3_ff;
         r4_ff   <= r3_ff;
      end
   end

   // ---------------- stage 5: sum partial products ----------------
   logic                 s5_v_ff;
   logic [SPW-1:0]       splo_in, sphi_in;
   logic [SPW-1:0]       splo_ff, sphi_ff;
   logic signed [QW-1:0] q5_ff;
   logic signed [RW-1:0] r5_ff;

   always_comb begin
      splo_in = '0;
      sphi_in = '0;
      for (int i = 0; i < NCH; i++) begin
         splo_in = splo_in + (SPW'(pplo_ff[i]) << (i*MW));
         sphi_in = sphi_in + (SPW'(pphi_ff[i]) << (i*MW));
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         splo_ff <= splo_in;
         sphi_ff <= sphi_in;
         q5_ff   <= q4_ff;
         r5_ff   <= r4_ff;
      end
   end

   // ---------------- stage 6: numerator sqrt3*P - 3*2^62*2Q ----------------
   logic                   s6_v_ff;
   logic signed [NUMW-1:0] q_wide, t6, num6_in;
   logic signed [NUMW-1:0] num6_ff;
   logic signed [RW-1:0]   r6_ff;

   always_comb begin
      q_wide  = NUMW'(q5_ff);
      t6      = (q_wide <<< (K+1)) + (q_wide <<< K);
      num6_in = $signed(NUMW'(splo_ff) + (NUMW'(sphi_ff) << MW)) - t6;
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         num6_ff <= num6_in;
         r6_ff   <= r5_ff;
      end
   end

   // ---------------- stage 7: magnitudes and signs ----------------
   logic                     s7_v_ff;
   logic signed [NUMW-1:0]   num_neg;
   logic signed [RW-1:0]     r_neg;
   logic [MAGW-1:0]          mag7_in, mag7_ff;
   logic [RAW-1:0]           rabs7_in, rabs7_ff;
   amte_pkg::amte_flags_type flags7_in, flags7_ff;

   always_comb begin
      num_neg         = -num6_ff;
      r_neg           = -r6_ff;
      mag7_in         = num6_ff[NUMW-1] ? num_neg[MAGW-1:0] : num6_ff[MAGW-1:0];
      rabs7_in        = r6_ff[RW-1] ? r_neg[RAW-1:0] : r6_ff[RAW-1:0];
      flags7_in.neg   = num6_ff[NUMW-1] ^ r6_ff[RW-1];
      flags7_in.degen = (r6_ff == '0);
      flags7_in.big   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         mag7_ff   <= mag7_in;
         rabs7_ff  <= rabs7_in;
         flags7_ff <= flags7_in;
      end
   end

   // ---------------- stage 8: scaled dividend with half divisor, divisor ----------------
   logic                     s8_v_ff;
   logic [XW-1:0]            r_x, x8_in, x8_ff;
   logic [DDW-1:0]           r_d, d8_in, d8_ff;
   amte_pkg::amte_flags_type flags8_ff;

   always_comb begin
      r_x   = XW'(rabs7_ff);
      r_d   = DDW'(rabs7_ff);
      // add half the divisor (3*2^62*|R|) to round ties away from zero
      x8_in = (XW'(mag7_ff) << amte_pkg::ENERGY_FRAC) + (r_x << (K+1)) + (r_x << K);
      d8_in = (r_d << (K+2)) + (r_d << (K+1));
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         x8_ff     <= x8_in;
         d8_ff     <= d8_in;
         flags8_ff <= flags7_ff;
      end
   end

   // ---------------- valid bits of stages 1 to 8 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
      end else if (pipe_adv) begin
         s1_v_ff <= s0_v;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         s8_v_ff <= s7_v_ff;
      end
   end

   // ---------------- divider ----------------
   logic                     div_v;
   logic [EW-1:0]            div_quo;
   amte_pkg::amte_flags_type div_flags;

   amte_divider #(
      .XW  (XW),
      .DDW (DDW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_adv),
      .in_valid  (s8_v_ff),
      .in_num    (x8_ff),
      .in_den    (d8_ff),
      .in_flags  (flags8_ff),
      .out_valid (div_v),
      .out_quo   (div_quo),
      .out_flags (div_flags)
   );

   // ---------------- output register: saturate and sign ----------------
   logic          over;
   logic [EW-1:0] energy_in, energy_ff;
   logic          sat_in, sat_ff, degen_ff;

   always_comb begin
      // magnitude limit is 2^31 for negative results and 2^31-1 for positive ones
      over = div_flags.big ||
             (div_flags.neg ? (div_quo[EW-1] && (|div_quo[EW-2:0])) : div_quo[EW-1]);
      priority if (div_flags.degen) begin
         energy_in = amte_pkg::ENERGY_MAX;
         sat_in    = 1'b0;
      end else if (over) begin
         energy_in = div_flags.neg ? amte_pkg::ENERGY_MIN : amte_pkg::ENERGY_MAX;
         sat_in    = 1'b1;
      end else begin
         energy_in = div_flags.neg ? (EW'(0) - div_quo) : div_quo;
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (pipe_adv) begin
         rsp_v_ff <= div_v;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         energy_ff <= energy_in;
         sat_ff    <= sat_in;
         degen_ff  <= div_flags.degen;
      end
   end

   always_comb begin
      rsp_tuser                       = '0;
      rsp_tuser[amte_pkg::USER_DEGEN] = degen_ff;
      rsp_tuser[amte_pkg::USER_SAT]   = sat_ff;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = energy_ff;

endmodule

@@ rtl/core/amte_checker.sv @@
// Port-level checks of the triangle energy unit, bound to the top level.
`timescale 1ns / 1ps

module amte_checker #(
   parameter int COORD_WIDTH = amte_pkg::COORD_WIDTH_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((6*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [amte_pkg::ENERGY_W-1:0]       rsp_tdata,
   input logic [amte_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   logic degen, sat;
   logic unused_data;

   assign degen       = rsp_tuser[amte_pkg::USER_DEGEN];
   assign sat         = rsp_tuser[amte_pkg::USER_SAT];
   assign unused_data = ^req_tdata;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a degenerate triangle reads as the largest energy and never as clamped
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && degen |-> rsp_tdata == amte_pkg::ENERGY_MAX && !sat)
      else $error("degenerate result with wrong energy or flags");

   // a clamped result sits on one of the two range limits
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && sat |->
         rsp_tdata == amte_pkg::ENERGY_MAX || rsp_tdata == amte_pkg::ENERGY_MIN)
      else $error("saturated result off the range limits");

   // the input closes only after an item went into the skid slot during a stall
   a_skid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |->
         $past(req_tvalid && req_tready) ||
         ($past(!req_tready) && $past(rsp_tvalid && !rsp_tready)))
      else $error("input not ready without a pending stalled item");

endmodule

bind amips_triangle_energy_unit amte_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_amte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
